>>> rtl/tash_pkg.sv
// ----------------------------------------------------------------------------
// tash_pkg
// Shared constants for the stable Heron triangle area block.
// ----------------------------------------------------------------------------
package tash_pkg;

  // Width of the area result, unsigned Q26.24
  localparam int unsigned AREA_W = 50;

endpackage

>>> rtl/tash_in_if.sv
// ----------------------------------------------------------------------------
// tash_in_if
// Triangle input channel: three vertices, signed Q12.12 coordinates.
// ----------------------------------------------------------------------------
interface tash_in_if #(
  parameter int unsigned COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    input  ready
  );
  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    output ready
  );
endinterface

>>> rtl/tash_out_if.sv
// ----------------------------------------------------------------------------
// tash_out_if
// Area result channel: unsigned Q26.24 area and degenerate flag.
// ----------------------------------------------------------------------------
interface tash_out_if;
  logic                        valid;
  logic                        ready;
  logic [tash_pkg::AREA_W-1:0] area;
  logic                        degenerate;

  modport source (
    output valid, area, degenerate,
    input  ready
  );
  modport sink (
    input  valid, area, degenerate,
    output ready
  );
endinterface

>>> rtl/tash_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// tash_sqrt_pipe
// Restoring square root, one result bit per register stage. Gives the floor
// root and the remainder (value - root^2) after N stages.
// ----------------------------------------------------------------------------
module tash_sqrt_pipe #(
  parameter int unsigned N = 25
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*N-1:0] val_i,
  output logic [N-1:0]   root_o,
  output logic [N+1:0]   rem_o
);

  logic [2*N-1:0] v_q [N];
  logic [N-1:0]   r_q [N];
  logic [N+1:0]   m_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stg
    logic [2*N-1:0] v_in;
    logic [N-1:0]   r_in;
    logic [N+1:0]   m_in;
    logic [N+2:0]   cur;
    logic [N+2:0]   trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in = val_i;
      assign r_in = '0;
      assign m_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
      assign m_in = m_q[k-1];
    end

    // bring down the next two bits, try root bit one
    // partial remainder before the last stage stays below 2^(N+1)
    assign cur   = {m_in[N:0], v_in[2*N-1 -: 2]};
    assign trial = {1'b0, r_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_in << 2;
        r_q[k] <= {r_in[N-2:0], ge};
        m_q[k] <= ge ? (N+2)'(cur - trial) : cur[N+1:0];
      end
    end
  end

  assign root_o = r_q[N-1];
  assign rem_o  = m_q[N-1];

endmodule

>>> rtl/triangle_area_stable_heron.sv
// ----------------------------------------------------------------------------
// triangle_area_stable_heron
// Triangle area from three 3D vertices by Kahan's stable Heron form.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   ax ay az bx by_coord bz cx cy cz (signed)
//   out_o    out  valid/ready   area (unsigned Q26.24), degenerate
//
// One triangle enters per cycle while the output is not held; the pipeline
// depth comes mostly from the two bit-per-stage square root pipelines.
// Reset clears only the stage valid bits. When the output holds an untaken
// result the whole pipeline freezes and in_i.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module triangle_area_stable_heron #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tash_in_if.sink    in_i,
  tash_out_if.source out_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = CB + 1;       // coordinate difference
  localparam int unsigned SQW = 2 * CB;       // one squared difference
  localparam int unsigned SW  = 2 * CB + 2;   // squared edge length
  localparam int unsigned EW  = CB + 1;       // edge length
  localparam int unsigned FW  = CB + 4;       // signed Heron factor
  localparam int unsigned HW  = CB + 3;       // positive factor
  localparam int unsigned PW  = 2 * HW;       // pair product
  localparam int unsigned QW  = 2 * PW;       // full Heron product
  localparam int unsigned LAT = EW + PW + 11;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // vertex / coordinate view of the input
  logic signed [CB-1:0] vt [3][3];
  assign vt[0][0] = in_i.ax;
  assign vt[0][1] = in_i.ay;
  assign vt[0][2] = in_i.az;
  assign vt[1][0] = in_i.bx;
  assign vt[1][1] = in_i.by_coord;
  assign vt[1][2] = in_i.bz;
  assign vt[2][0] = in_i.cx;
  assign vt[2][1] = in_i.cy;
  assign vt[2][2] = in_i.cz;

  logic signed [DW-1:0] d_q   [3][3];
  logic [SQW-1:0]       sq_q  [3][3];
  logic [SW-1:0]        s_q   [3];
  logic [EW-1:0]        root  [3];
  logic [EW+1:0]        rem   [3];
  logic [EW-1:0]        e_q   [3];

  // edges A-B, B-C, C-A
  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [2*DW-1:0] prod;
      assign prod = d_q[e][k] * d_q[e][k];

      always_ff @(posedge clk_i) begin
        if (en) begin
          d_q[e][k]  <= DW'(vt[e][k]) - DW'(vt[(e+1)%3][k]);
          sq_q[e][k] <= prod[SQW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q[e] <= SW'(sq_q[e][0]) + SW'(sq_q[e][1]) + SW'(sq_q[e][2]);
        // round to nearest: bump when remainder exceeds root
        e_q[e] <= root[e] + EW'((rem[e] > (EW+2)'(root[e])));
      end
    end

    tash_sqrt_pipe #(.N(EW)) u_edge_root (
      .clk_i  (clk_i),
      .en_i   (en),
      .val_i  (s_q[e]),
      .root_o (root[e]),
      .rem_o  (rem[e])
    );
  end

  // sort x >= y >= z
  logic [EW-1:0] s0x, s0y, s1y, s1z, s2x, s2y;
  logic [EW-1:0] x_q, y_q, z_q;

  always_comb begin
    s0x = (e_q[0] < e_q[1]) ? e_q[1] : e_q[0];
    s0y = (e_q[0] < e_q[1]) ? e_q[0] : e_q[1];
    s1y = (s0y < e_q[2]) ? e_q[2] : s0y;
    s1z = (s0y < e_q[2]) ? s0y : e_q[2];
    s2x = (s0x < s1y) ? s1y : s0x;
    s2y = (s0x < s1y) ? s0x : s1y;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= s2x;
      y_q <= s2y;
      z_q <= s1z;
    end
  end

  // Heron factors, parenthesization kept
  logic signed [FW-1:0] xs, ys, zs, f1, f2, f3, f4;
  logic signed [FW-1:0] f1_q, f2_q, f3_q, f4_q;
  logic                 dg_d;

  assign xs   = signed'(FW'(x_q));
  assign ys   = signed'(FW'(y_q));
  assign zs   = signed'(FW'(z_q));
  assign f1   = xs + (ys + zs);
  assign f2   = zs - (xs - ys);
  assign f3   = zs + (xs - ys);
  assign f4   = xs + (ys - zs);
  assign dg_d = (f1 <= 0) || (f2 <= 0) || (f3 <= 0) || (f4 <= 0);

  // degenerate flag rides alongside the product and wide root stages
  logic [PW+4:0] dg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q <= f1;
      f2_q <= f2;
      f3_q <= f3;
      f4_q <= f4;
      dg_q <= {dg_q[PW+3:0], dg_d};
    end
  end

  logic [PW-1:0] p1_q, p2_q;
  logic [PW-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [PW:0]   mid_q;
  logic [PW-1:0] ll2_q, hh2_q;
  logic [QW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= PW'(f1_q[HW-1:0]) * PW'(f2_q[HW-1:0]);
      p2_q   <= PW'(f3_q[HW-1:0]) * PW'(f4_q[HW-1:0]);
      // wide product split into four partial products
      ll_q   <= PW'(p1_q[HW-1:0]) * PW'(p2_q[HW-1:0]);
      lh_q   <= PW'(p1_q[HW-1:0]) * PW'(p2_q[PW-1:HW]);
      hl_q   <= PW'(p1_q[PW-1:HW]) * PW'(p2_q[HW-1:0]);
      hh_q   <= PW'(p1_q[PW-1:HW]) * PW'(p2_q[PW-1:HW]);
      mid_q  <= (PW+1)'(lh_q) + (PW+1)'(hl_q);
      ll2_q  <= ll_q;
      hh2_q  <= hh_q;
      prod_q <= {hh2_q, ll2_q} + (QW'(mid_q) << HW);
    end
  end

  logic [PW-1:0] wroot;
  logic [PW+1:0] wrem;

  tash_sqrt_pipe #(.N(PW)) u_area_root (
    .clk_i  (clk_i),
    .en_i   (en),
    .val_i  (prod_q),
    .root_o (wroot),
    .rem_o  (wrem)
  );

  // quarter root, rounded half up
  logic [PW:0] rnd;
  logic [tash_pkg::AREA_W-1:0] area_q;
  logic                        degen_q;

  assign rnd = (PW+1)'(wroot) + (PW+1)'(2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      area_q  <= dg_q[PW+4] ? '0 : tash_pkg::AREA_W'(rnd[PW:2]);
      degen_q <= dg_q[PW+4];
    end
  end

  assign out_o.area       = area_q;
  assign out_o.degenerate = degen_q;

endmodule
